@@ rtl/vertical_fade_to_color_assert.svh @@
// Assertion macros for the vertical fade block.
// Used by the port checker; depends on nothing else.
`ifndef VERTICAL_FADE_TO_COLOR_ASSERT_SVH
`define VERTICAL_FADE_TO_COLOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VFTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vftc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VFTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vftc assertion failed");

`endif

@@ rtl/vftc_pkg.sv @@
// Shared constants, types and helper functions for the vertical fade block.
// Used by every module of the block; depends on nothing.
package vftc_pkg;

    // Largest fade span in rows, and the widths that follow from it.
    localparam int MAX_FADE_SPAN = 4096;
    localparam int CH_W          = 8;
    localparam int CFG_W         = 13;
    localparam int SPAN_W        = $clog2(MAX_FADE_SPAN) + 1;
    localparam int POS_W         = SPAN_W + 1;
    localparam int POS_LO        = -2 * MAX_FADE_SPAN;
    localparam int POS_HI        = 2 * MAX_FADE_SPAN - 1;

    // Divider geometry: the product magnitude is retired a few bits per cycle.
    localparam int MAG_W      = CH_W + POS_W;
    localparam int RADIX_BITS = 3;
    localparam int DIV_CYC    = (MAG_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int NUM_W      = DIV_CYC * RADIX_BITS;
    localparam int CNT_W      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int N_LANES    = 4;

    // Configuration register indexes.
    localparam int IDX_W = 3;
    typedef logic [IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_BG_RED      = 3'd0;
    localparam t_cfg_idx REG_BG_GREEN    = 3'd1;
    localparam t_cfg_idx REG_BG_BLUE     = 3'd2;
    localparam t_cfg_idx REG_BG_ALPHA    = 3'd3;
    localparam t_cfg_idx REG_OPACITY     = 3'd4;
    localparam t_cfg_idx REG_FADE_RANGE  = 3'd5;
    localparam t_cfg_idx REG_FADE_OFFSET = 3'd6;
    localparam t_cfg_idx REG_FADE_DOWN   = 3'd7;

    typedef logic [CH_W-1:0] t_chan;

    // Premultiplied background colour.
    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
    } t_bg;

    // Sequencer commands to the background unit.
    typedef struct packed {
        logic load_alpha;
        logic load_colour;
    } t_bg_ctrl;

    // Sequencer commands to the channel lanes.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctrl;

    // Truncating division by 255 for values up to 255 * 255.
    function automatic t_chan div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W+1:0] t;
        t = {2'b00, x} + 18'(x >> CH_W) + 18'd1;
        return t_chan'(t >> CH_W);
    endfunction

    // Range register as used by the ramp: zero reads as one, clipped to the span.
    function automatic logic [SPAN_W-1:0] eff_range(input logic [CFG_W-1:0] raw);
        logic [SPAN_W-1:0] r;
        if (raw == '0) begin
            r = SPAN_W'(1);
        end else if (32'(raw) > 32'(MAX_FADE_SPAN)) begin
            r = SPAN_W'(MAX_FADE_SPAN);
        end else begin
            r = SPAN_W'(raw);
        end
        return r;
    endfunction

endpackage

@@ rtl/vftc_bg.sv @@
// Background colour unit: scales the alpha by the opacity, then premultiplies.
// Depends on vftc_pkg; driven by the sequencer in the top level.
module vftc_bg (
    input  logic                  i_clk,
    input  vftc_pkg::t_bg_ctrl    i_ctrl,
    input  vftc_pkg::t_chan       i_bg_red,
    input  vftc_pkg::t_chan       i_bg_green,
    input  vftc_pkg::t_chan       i_bg_blue,
    input  vftc_pkg::t_chan       i_bg_alpha,
    input  vftc_pkg::t_chan       i_opacity,
    output vftc_pkg::t_bg         o_bg
);

    vftc_pkg::t_chan r_alpha;
    vftc_pkg::t_bg   r_bg;

    // First step: effective background alpha.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_alpha) begin
            r_alpha <= vftc_pkg::div255(16'(i_bg_alpha) * 16'(i_opacity));
        end
    end

    // Second step: each colour channel scaled by that alpha.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_colour) begin
            r_bg.red   <= vftc_pkg::div255(16'(i_bg_red) * 16'(r_alpha));
            r_bg.green <= vftc_pkg::div255(16'(i_bg_green) * 16'(r_alpha));
            r_bg.blue  <= vftc_pkg::div255(16'(i_bg_blue) * 16'(r_alpha));
            r_bg.alpha <= r_alpha;
        end
    end

    assign o_bg = r_bg;

endmodule

@@ rtl/vftc_lane.sv @@
// One channel lane: multiplies the difference by the position, then divides
// by the range a few bits per cycle. Depends on vftc_pkg.
module vftc_lane (
    input  logic                         i_clk,
    input  vftc_pkg::t_lane_ctrl         i_ctrl,
    input  vftc_pkg::t_chan              i_pix,
    input  vftc_pkg::t_chan              i_bg,
    input  logic signed [vftc_pkg::POS_W-1:0] i_pos,
    input  logic [vftc_pkg::SPAN_W-1:0]  i_range,
    output vftc_pkg::t_chan              o_result
);

    logic [vftc_pkg::NUM_W-1:0]  r_num;
    logic [vftc_pkg::SPAN_W-1:0] r_rem;
    logic                        r_neg;
    vftc_pkg::t_chan             r_bg;

    logic signed [vftc_pkg::CH_W:0]   diff;
    logic [vftc_pkg::CH_W-1:0]        mag_d;
    logic [vftc_pkg::POS_W-1:0]       mag_p;
    logic [vftc_pkg::MAG_W-1:0]       product;
    logic [vftc_pkg::NUM_W-1:0]       n_num;
    logic [vftc_pkg::SPAN_W-1:0]      n_rem;
    logic [vftc_pkg::SPAN_W:0]        rem_sh;
    vftc_pkg::t_chan                  quo;

    // Signed product taken apart into magnitude and sign.
    always_comb begin
        diff    = $signed({1'b0, i_pix}) - $signed({1'b0, i_bg});
        mag_d   = diff[vftc_pkg::CH_W] ? vftc_pkg::CH_W'(-diff) : diff[vftc_pkg::CH_W-1:0];
        mag_p   = i_pos[vftc_pkg::POS_W-1] ? vftc_pkg::POS_W'(-i_pos)
                                           : vftc_pkg::POS_W'(i_pos);
        product = vftc_pkg::MAG_W'(mag_d * mag_p);
    end

    // Restoring division steps: quotient bits shift in at the bottom.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        rem_sh = '0;
        for (int k = 0; k < vftc_pkg::RADIX_BITS; k++) begin
            rem_sh = {n_rem, n_num[vftc_pkg::NUM_W-1]};
            n_num  = {n_num[vftc_pkg::NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, i_range}) begin
                rem_sh   = rem_sh - {1'b0, i_range};
                n_num[0] = 1'b1;
            end
            n_rem = rem_sh[vftc_pkg::SPAN_W-1:0];
        end
    end

    // Load the magnitude on request, then iterate.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_num <= vftc_pkg::NUM_W'(product);
            r_rem <= '0;
            r_neg <= diff[vftc_pkg::CH_W] ^ i_pos[vftc_pkg::POS_W-1];
            r_bg  <= i_bg;
        end else if (i_ctrl.step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // Truncation toward zero, then the background is added back; low bits only.
    always_comb begin
        quo      = r_neg ? vftc_pkg::CH_W'(-r_num[vftc_pkg::CH_W-1:0])
                         : r_num[vftc_pkg::CH_W-1:0];
        o_result = vftc_pkg::CH_W'(quo + r_bg);
    end

endmodule

@@ rtl/vertical_fade_to_color.sv @@
// Vertical fade of an RGBA pixel stream toward a premultiplied background colour.
// Each pixel is taken in the idle state, then runs through the alpha, colour,
// multiply, divide and finish states; the input stalls until the result is
// registered. Each of the four lanes has its own three-bits-per-cycle divider.
// Reset (synchronous, active low) restores the register defaults and position 0.
module vertical_fade_to_color (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  vftc_pkg::t_cfg_idx            i_cfg_index,
    input  logic [vftc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  vftc_pkg::t_chan               i_pix_red,
    input  vftc_pkg::t_chan               i_pix_green,
    input  vftc_pkg::t_chan               i_pix_blue,
    input  vftc_pkg::t_chan               i_pix_alpha,
    input  logic                          i_row_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output vftc_pkg::t_chan               o_out_red,
    output vftc_pkg::t_chan               o_out_green,
    output vftc_pkg::t_chan               o_out_blue,
    output vftc_pkg::t_chan               o_out_alpha,
    output logic                          o_out_row_end
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ALPHA  = 3'd1;
    localparam logic [2:0] ST_COLOUR = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // Configuration registers.
    vftc_pkg::t_chan                r_bg_red, r_bg_green, r_bg_blue, r_bg_alpha, r_opacity;
    logic [vftc_pkg::CFG_W-1:0]     r_fade_range, r_fade_offset;
    logic                           r_fade_down;
    logic [vftc_pkg::CFG_W-1:0]     n_fade_range, n_fade_offset;
    logic                           n_fade_down;

    // Ramp position, and the copy used by the pixel at work.
    logic signed [vftc_pkg::POS_W-1:0] r_pos, n_pos, r_item_pos;
    logic [vftc_pkg::SPAN_W-1:0]       r_item_range;

    // Sequencer and captured pixel.
    logic [2:0]                  r_state, n_state;
    logic [vftc_pkg::CNT_W-1:0]  r_cnt;
    vftc_pkg::t_chan             r_pix [vftc_pkg::N_LANES];
    logic                        r_row_end;

    // Output register.
    logic            r_out_valid, r_out_row_end;
    vftc_pkg::t_chan r_out [vftc_pkg::N_LANES];

    logic                 in_take, out_free;
    int                   reload;
    vftc_pkg::t_bg_ctrl   bg_ctrl;
    vftc_pkg::t_lane_ctrl lane_ctrl;
    vftc_pkg::t_bg        bg;
    vftc_pkg::t_chan      bg_chan [vftc_pkg::N_LANES];
    vftc_pkg::t_chan      result  [vftc_pkg::N_LANES];

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Register values after this cycle's write, used for the ramp reload.
    always_comb begin
        n_fade_range  = r_fade_range;
        n_fade_offset = r_fade_offset;
        n_fade_down   = r_fade_down;
        if (i_cfg_we) begin
            case (i_cfg_index)
                vftc_pkg::REG_FADE_RANGE:  n_fade_range  = i_cfg_data;
                vftc_pkg::REG_FADE_OFFSET: n_fade_offset = i_cfg_data;
                vftc_pkg::REG_FADE_DOWN:   n_fade_down   = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next position: a reload on a ramp write, otherwise a saturating row step.
    always_comb begin
        reload = n_fade_down ? int'(vftc_pkg::eff_range(n_fade_range)) - int'(n_fade_offset)
                             : int'(n_fade_offset);
        if (reload < vftc_pkg::POS_LO) begin
            reload = vftc_pkg::POS_LO;
        end else if (reload > vftc_pkg::POS_HI) begin
            reload = vftc_pkg::POS_HI;
        end
        n_pos = r_pos;
        if (i_cfg_we && (i_cfg_index == vftc_pkg::REG_FADE_RANGE ||
                         i_cfg_index == vftc_pkg::REG_FADE_OFFSET ||
                         i_cfg_index == vftc_pkg::REG_FADE_DOWN)) begin
            n_pos = vftc_pkg::POS_W'(reload);
        end else if (in_take && i_row_end) begin
            if (r_fade_down) begin
                if (int'(r_pos) > vftc_pkg::POS_LO) begin
                    n_pos = r_pos - vftc_pkg::POS_W'(1);
                end
            end else begin
                if (int'(r_pos) < vftc_pkg::POS_HI) begin
                    n_pos = r_pos + vftc_pkg::POS_W'(1);
                end
            end
        end
    end

    // Configuration and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_red      <= '0;
            r_bg_green    <= '0;
            r_bg_blue     <= '0;
            r_bg_alpha    <= 8'd255;
            r_opacity     <= 8'd255;
            r_fade_range  <= vftc_pkg::CFG_W'(1);
            r_fade_offset <= '0;
            r_fade_down   <= 1'b0;
            r_pos         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vftc_pkg::REG_BG_RED:   r_bg_red   <= i_cfg_data[7:0];
                    vftc_pkg::REG_BG_GREEN: r_bg_green <= i_cfg_data[7:0];
                    vftc_pkg::REG_BG_BLUE:  r_bg_blue  <= i_cfg_data[7:0];
                    vftc_pkg::REG_BG_ALPHA: r_bg_alpha <= i_cfg_data[7:0];
                    vftc_pkg::REG_OPACITY:  r_opacity  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_fade_range  <= n_fade_range;
            r_fade_offset <= n_fade_offset;
            r_fade_down   <= n_fade_down;
            r_pos         <= n_pos;
        end
    end

    // Sequencer: one pixel at a time through setup, multiply and divide.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_ALPHA;
            ST_ALPHA:  n_state = ST_COLOUR;
            ST_COLOUR: n_state = ST_MUL;
            ST_MUL:    n_state = ST_DIV;
            ST_DIV:    if (r_cnt == vftc_pkg::CNT_W'(vftc_pkg::DIV_CYC - 1)) n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + vftc_pkg::CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Capture the pixel, its flag and the ramp values it sees.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pix[0]     <= i_pix_red;
            r_pix[1]     <= i_pix_green;
            r_pix[2]     <= i_pix_blue;
            r_pix[3]     <= i_pix_alpha;
            r_row_end    <= i_row_end;
            r_item_pos   <= r_pos;
            r_item_range <= vftc_pkg::eff_range(r_fade_range);
        end
    end

    assign bg_ctrl.load_alpha  = (r_state == ST_ALPHA);
    assign bg_ctrl.load_colour = (r_state == ST_COLOUR);
    assign lane_ctrl.load      = (r_state == ST_MUL);
    assign lane_ctrl.step      = (r_state == ST_DIV);

    vftc_bg u_bg (
        .i_clk      (i_clk),
        .i_ctrl     (bg_ctrl),
        .i_bg_red   (r_bg_red),
        .i_bg_green (r_bg_green),
        .i_bg_blue  (r_bg_blue),
        .i_bg_alpha (r_bg_alpha),
        .i_opacity  (r_opacity),
        .o_bg       (bg)
    );

    assign bg_chan[0] = bg.red;
    assign bg_chan[1] = bg.green;
    assign bg_chan[2] = bg.blue;
    assign bg_chan[3] = bg.alpha;

    // Four channel lanes working side by side.
    for (genvar g = 0; g < vftc_pkg::N_LANES; g++) begin : g_lane
        vftc_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_pix    (r_pix[g]),
            .i_bg     (bg_chan[g]),
            .i_pos    (r_item_pos),
            .i_range  (r_item_range),
            .o_result (result[g])
        );
    end

    // Merge the lane results into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            for (int k = 0; k < vftc_pkg::N_LANES; k++) begin
                r_out[k] <= result[k];
            end
            r_out_row_end <= r_row_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_red     = r_out[0];
    assign o_out_green   = r_out[1];
    assign o_out_blue    = r_out[2];
    assign o_out_alpha   = r_out[3];
    assign o_out_row_end = r_out_row_end;

endmodule

@@ rtl/vftc_checker.sv @@
// Port checker for the vertical fade block, bound to the top level.
// Depends on vftc_pkg and the assertion macro header.
`include "vertical_fade_to_color_assert.svh"

module vftc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input vftc_pkg::t_chan            o_out_red,
    input vftc_pkg::t_chan            o_out_green,
    input vftc_pkg::t_chan            o_out_blue,
    input vftc_pkg::t_chan            o_out_alpha,
    input logic                       o_out_row_end
);

    // A stalled result stays offered.
    `VFTC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its payload.
    `VFTC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha) && $stable(o_out_row_end))

    // One pixel at a time: taking a request closes the input for the next cycle.
    `VFTC_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall)

    // A fresh pixel cannot produce its result in the very next cycle.
    `VFTC_ASSERT_NEXT(a_no_early, i_in_valid && !o_in_stall && !o_out_valid, !o_out_valid)

endmodule

bind vertical_fade_to_color vftc_checker u_vftc_checker (.*);
